### hdl/asn1_time_to_epoch_seconds_macros.svh
// Assertion shorthands used by the checker file of this block.
`ifndef ASN1_TIME_TO_EPOCH_SECONDS_MACROS_SVH
`define ASN1_TIME_TO_EPOCH_SECONDS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define A1TE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define A1TE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/a1te_pkg.sv
package a1te_pkg;

	localparam int PAIR_W = 13;
	localparam int YEAR_W = 19;
	localparam int MAG_W = 18;
	localparam int MON_W = 4;
	localparam int DAY_W = 5;
	localparam int MDAY_W = 9;
	localparam int DAYS_W = 27;
	localparam int TOD_W = 25;
	localparam int OUT_W = 44;

	localparam int PIPE_DEPTH = 6;

	localparam int BYTE_BIAS = 48;
	// A digit pair is hi * 10 + lo with both bytes biased, so the total bias is 11 times.
	localparam int PAIR_BIAS = BYTE_BIAS * 11;

	localparam int EPOCH_YEAR = 1970;
	localparam int UTC_BASE_YEAR = 2000;
	localparam int CENTURY = 100;
	localparam int DAYS_PER_YEAR = 365;
	localparam int LEAPS_BEFORE_EPOCH =
		(EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100 + (EPOCH_YEAR - 1) / 400;
	localparam int SECS_PER_DAY = 86400;
	localparam int SECS_PER_HOUR = 3600;
	localparam int SECS_PER_MIN = 60;

	localparam int UTC_MIN_LEN = 12;
	localparam int GEN_MIN_LEN = 14;

	localparam int MON_LO = 1;
	localparam int MON_HI = 12;
	localparam int DAY_LO = 1;
	localparam int DAY_HI = 31;

	typedef struct packed {
		logic short_f;
		logic signed [YEAR_W-1:0] year;
		logic [MON_W-1:0] mon;
		logic [DAY_W-1:0] day;
		logic signed [PAIR_W-1:0] hh;
		logic signed [PAIR_W-1:0] mm;
		logic signed [PAIR_W-1:0] ss;
	} dec_t;

	function automatic logic signed [PAIR_W-1:0] pair_val(input logic [7:0] hi,
			input logic [7:0] lo);
		logic [PAIR_W-2:0] raw;
		raw = (PAIR_W-1)'(hi) * (PAIR_W-1)'(10) + (PAIR_W-1)'(lo);
		return PAIR_W'($signed({1'b0, raw}) - PAIR_W'(PAIR_BIAS));
	endfunction

	// Days in the months of a non-leap year that come before the given month.
	function automatic logic [MDAY_W-1:0] cum_days(input logic [MON_W-1:0] mon);
		logic [MDAY_W-1:0] d;
		case (mon)
			4'd1: d = 9'd0;
			4'd2: d = 9'd31;
			4'd3: d = 9'd59;
			4'd4: d = 9'd90;
			4'd5: d = 9'd120;
			4'd6: d = 9'd151;
			4'd7: d = 9'd181;
			4'd8: d = 9'd212;
			4'd9: d = 9'd243;
			4'd10: d = 9'd273;
			4'd11: d = 9'd304;
			4'd12: d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

### hdl/a1te_decode.sv
module a1te_decode import a1te_pkg::*; (
	input logic is_utc,
	input logic [7:0] field_length,
	input logic [55:0] chars_first,
	input logic [55:0] chars_second,
	output dec_t dec
);

	localparam int NBYTES = 14;
	localparam int NPAIRS = NBYTES / 2;

	logic [8*NBYTES-1:0] chars;
	logic [7:0] bytes_c [NBYTES];
	logic signed [PAIR_W-1:0] pr [NPAIRS];
	logic signed [YEAR_W-1:0] year_utc;
	logic signed [YEAR_W-1:0] year_gen;
	logic signed [PAIR_W-1:0] mon_raw;
	logic signed [PAIR_W-1:0] day_raw;

	always_comb begin
		chars = {chars_first, chars_second};
		for (int k = 0; k < NBYTES; k++) begin
			bytes_c[k] = chars[8*NBYTES-1-8*k -: 8];
		end
		for (int j = 0; j < NPAIRS; j++) begin
			pr[j] = pair_val(bytes_c[2*j], bytes_c[2*j+1]);
		end
	end

	always_comb begin
		year_utc = YEAR_W'(pr[0]) + YEAR_W'(UTC_BASE_YEAR);
		year_gen = YEAR_W'(pr[0]) * YEAR_W'(CENTURY) + YEAR_W'(pr[1]);

		// A UTCTime field has a two-digit year, so every later pair sits one place earlier.
		if (is_utc) begin
			dec.year = year_utc;
			mon_raw = pr[1];
			day_raw = pr[2];
			dec.hh = pr[3];
			dec.mm = pr[4];
			dec.ss = pr[5];
			dec.short_f = field_length < 8'(UTC_MIN_LEN);
		end else begin
			dec.year = year_gen;
			mon_raw = pr[2];
			day_raw = pr[3];
			dec.hh = pr[4];
			dec.mm = pr[5];
			dec.ss = pr[6];
			dec.short_f = field_length < 8'(GEN_MIN_LEN);
		end

		if (mon_raw < PAIR_W'(MON_LO)) begin
			dec.mon = MON_W'(MON_LO);
		end else if (mon_raw > PAIR_W'(MON_HI)) begin
			dec.mon = MON_W'(MON_HI);
		end else begin
			dec.mon = MON_W'(mon_raw);
		end

		if (day_raw < PAIR_W'(DAY_LO)) begin
			dec.day = DAY_W'(DAY_LO);
		end else if (day_raw > PAIR_W'(DAY_HI)) begin
			dec.day = DAY_W'(DAY_HI);
		end else begin
			dec.day = DAY_W'(day_raw);
		end
	end

endmodule

### hdl/asn1_time_to_epoch_seconds.sv
// Converts one ASN.1 time field (UTCTime or GeneralizedTime) to seconds since 1970.
// Input channel: in_valid / in_stall with is_utc, field_length, chars_first and
// chars_second; a transaction is taken at a clock edge with in_valid high and
// in_stall low. Output channel: out_valid / out_stall with epoch_seconds.
// A taken field passes through six register stages (decode, reciprocal multiplies
// for the leap-year divisions, year and month days, day and time-of-day sums, the
// multiply by seconds per day, final add) and shows on out_valid from the last.
// One transaction enters and one result leaves per cycle while the output is not
// stalled.
// A short field yields zero and still takes the same path and latency.
// Reset clears every stage valid bit; the stage data registers are not reset.
// When the receiver stalls, the result holds on the output and each stage keeps
// its item until the stage ahead frees; empty stages still fill, so in_stall
// rises only when all six stages are full and the output is stalled.
module asn1_time_to_epoch_seconds import a1te_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic is_utc,
	input logic [7:0] field_length,
	input logic [55:0] chars_first,
	input logic [55:0] chars_second,
	output logic out_valid,
	input logic out_stall,
	output logic signed [OUT_W-1:0] epoch_seconds
);

	// Division by 25 as a multiply by a rounded-up reciprocal; exact for the
	// operand widths used below.
	localparam int RQ_SHIFT = 21;
	localparam int RQ_K = (2 ** RQ_SHIFT + 24) / 25;
	localparam int RA_SHIFT = 23;
	localparam int RA_K = (2 ** RA_SHIFT + 24) / 25;
	localparam int PROD_W = 40;
	localparam int Q100_W = 12;
	localparam int Q400_W = 10;
	localparam int Q25_W = 14;

	dec_t dec;

	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	dec_t d_s1, d_s2, d_s3, d_s4;

	logic [MAG_W-1:0] mag_s2, nm1_s2;
	logic [Q100_W-1:0] q100_s2;
	logic [Q400_W-1:0] q400_s2;
	logic [Q25_W-1:0] q25_s2;

	logic [DAYS_W-1:0] days_y_s3;
	logic [MDAY_W-1:0] mday_s3;

	logic [DAYS_W-1:0] days_s4;
	logic signed [TOD_W-1:0] tod_s4;

	logic [OUT_W-1:0] dsec_s5;
	logic signed [TOD_W-1:0] tod_s5;
	logic short_s5;

	logic signed [OUT_W-1:0] epoch_s6;

	logic [MAG_W-1:0] mag_c, nm1_c;
	logic [PROD_W-1:0] p100_c, p400_c, p25_c;

	logic [MAG_W-1:0] back25_c;
	logic div25_c, leap_c, later_c;
	logic [DAYS_W-1:0] yd_c;

	a1te_decode u_decode (
		.is_utc(is_utc),
		.field_length(field_length),
		.chars_first(chars_first),
		.chars_second(chars_second),
		.dec(dec)
	);

	// A stage may load when it is empty or when the stage ahead moves on.
	assign rdy6 = !v_s6 || !out_stall;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	// Stage 2: magnitude and year - 1, then the reciprocal multiplies.
	always_comb begin
		mag_c = d_s1.year[YEAR_W-1] ? MAG_W'(-d_s1.year) : MAG_W'(d_s1.year);
		nm1_c = MAG_W'(d_s1.year - YEAR_W'(1));
		p100_c = PROD_W'(nm1_c[MAG_W-1:2]) * PROD_W'(RQ_K);
		p400_c = PROD_W'(nm1_c[MAG_W-1:4]) * PROD_W'(RQ_K);
		p25_c = PROD_W'(mag_c) * PROD_W'(RA_K);
	end

	// Stage 3: leap test and the days of whole years since the epoch.
	always_comb begin
		back25_c = MAG_W'(q25_s2) * MAG_W'(25);
		div25_c = back25_c == mag_s2;
		// Divisible by 100 is divisible by 4 and 25; by 400 adds a factor of 16.
		leap_c = (d_s2.year[1:0] == 2'b00) && (!div25_c || (d_s2.year[3:0] == 4'b0000));
		later_c = d_s2.year > YEAR_W'(EPOCH_YEAR);
		yd_c = DAYS_W'(d_s2.year - YEAR_W'(EPOCH_YEAR));
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			d_s1 <= dec;
		end
		if (rdy2) begin
			d_s2 <= d_s1;
			mag_s2 <= mag_c;
			nm1_s2 <= nm1_c;
			q100_s2 <= p100_c[RQ_SHIFT +: Q100_W];
			q400_s2 <= p400_c[RQ_SHIFT +: Q400_W];
			q25_s2 <= p25_c[RA_SHIFT +: Q25_W];
		end
		if (rdy3) begin
			d_s3 <= d_s2;
			if (later_c) begin
				days_y_s3 <= yd_c * DAYS_W'(DAYS_PER_YEAR) + DAYS_W'(nm1_s2[MAG_W-1:2])
					- DAYS_W'(q100_s2) + DAYS_W'(q400_s2) - DAYS_W'(LEAPS_BEFORE_EPOCH);
			end else begin
				days_y_s3 <= '0;
			end
			mday_s3 <= cum_days(d_s2.mon)
				+ MDAY_W'(leap_c && (d_s2.mon > MON_W'(2)))
				+ MDAY_W'(d_s2.day) - MDAY_W'(1);
		end
		if (rdy4) begin
			d_s4 <= d_s3;
			days_s4 <= days_y_s3 + DAYS_W'(mday_s3);
			tod_s4 <= TOD_W'(d_s3.hh) * TOD_W'(SECS_PER_HOUR)
				+ TOD_W'(d_s3.mm) * TOD_W'(SECS_PER_MIN) + TOD_W'(d_s3.ss);
		end
		if (rdy5) begin
			dsec_s5 <= OUT_W'(days_s4) * OUT_W'(SECS_PER_DAY);
			tod_s5 <= tod_s4;
			short_s5 <= d_s4.short_f;
		end
		if (rdy6) begin
			if (short_s5) begin
				epoch_s6 <= '0;
			end else begin
				epoch_s6 <= $signed(dsec_s5 + OUT_W'(tod_s5));
			end
		end
	end

	assign out_valid = v_s6;
	assign epoch_seconds = epoch_s6;

endmodule

### hdl/a1te_checker.sv
`include "asn1_time_to_epoch_seconds_macros.svh"

module a1te_checker import a1te_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [OUT_W-1:0] epoch_seconds
);

	localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

	logic [CNT_W-1:0] inflight_q;
	logic in_take, out_take;

	assign in_take = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;

	// Transactions taken in whose results have not yet been taken out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_take && !out_take) begin
			inflight_q <= inflight_q + CNT_W'(1);
		end else if (out_take && !in_take) begin
			inflight_q <= inflight_q - CNT_W'(1);
		end
	end

	`A1TE_ASSERT_IMP(a_no_spurious_out, clk, arst_n, out_valid, inflight_q != '0, "result with no pending transaction")
	`A1TE_ASSERT_IMP(a_depth_bound, clk, arst_n, 1'b1, inflight_q <= CNT_W'(PIPE_DEPTH), "more transactions in flight than stages")
	`A1TE_ASSERT_IMP(a_stall_source, clk, arst_n, in_stall, out_valid && out_stall, "input stalled while the output moves")
	`A1TE_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(epoch_seconds), "stalled result changed")

endmodule

bind asn1_time_to_epoch_seconds a1te_checker u_a1te_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.epoch_seconds(epoch_seconds)
);
